[design/rgbhsv_pkg.sv]
// Package for the RGB to HSV converter: pixel and result item types,
// pipeline control structs and conversion constants. Depends on nothing.
`default_nettype none

package rgbhsv_pkg;

	localparam int unsigned SECTOR_SPAN = 43;
	localparam int unsigned BASE_GREEN  = 85;
	localparam int unsigned BASE_BLUE   = 171;
	localparam int unsigned DIV_STEPS   = 8;
	localparam int unsigned PIPE_LATENCY = 3 + DIV_STEPS;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [7:0] hue;
		logic [7:0] saturation;
		logic [7:0] brightness;
	} hsv_t;

	// Data that rides alongside the dividers until the hue is assembled.
	typedef struct packed {
		logic       valid;
		logic [7:0] hi;
		logic [7:0] base;
		logic       neg;
	} side_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] hi;
		logic [7:0] span;
		logic [7:0] mag;
		logic       neg;
		logic [7:0] base;
	} front_t;

	typedef struct packed {
		side_t       side;
		logic [15:0] sat_num;
		logic [7:0]  sat_den;
		logic [15:0] hue_num;
		logic [7:0]  hue_den;
	} prod_t;

endpackage

`default_nettype wire

[design/rgbhsv_front.sv]
// Front end of the RGB to HSV converter: extremes, sector choice and the
// divider operands, over two register stages. Depends on rgbhsv_pkg.
`default_nettype none

module rgbhsv_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire rgbhsv_pkg::pixel_t pixel,
	output rgbhsv_pkg::prod_t      prod
);

	rgbhsv_pkg::front_t front_d;
	rgbhsv_pkg::front_t front_s1;
	rgbhsv_pkg::prod_t  prod_d;
	rgbhsv_pkg::prod_t  prod_s2;

	logic [7:0]       hi;
	logic [7:0]       lo;
	logic signed [8:0] diff;

	always_comb begin
		hi = (pixel.red > pixel.green) ? pixel.red : pixel.green;
		if (pixel.blue > hi) begin
			hi = pixel.blue;
		end
		lo = (pixel.red < pixel.green) ? pixel.red : pixel.green;
		if (pixel.blue < lo) begin
			lo = pixel.blue;
		end

		// Red wins ties for the largest channel, then green.
		if (hi == pixel.red) begin
			diff = $signed({1'b0, pixel.green}) - $signed({1'b0, pixel.blue});
			front_d.base = 8'd0;
		end else if (hi == pixel.green) begin
			diff = $signed({1'b0, pixel.blue}) - $signed({1'b0, pixel.red});
			front_d.base = 8'(rgbhsv_pkg::BASE_GREEN);
		end else begin
			diff = $signed({1'b0, pixel.red}) - $signed({1'b0, pixel.green});
			front_d.base = 8'(rgbhsv_pkg::BASE_BLUE);
		end

		front_d.valid = in_valid;
		front_d.hi    = hi;
		front_d.span  = hi - lo;
		front_d.neg   = diff[8];
		front_d.mag   = diff[8] ? 8'(-diff) : diff[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_s1 <= '0;
		end else begin
			front_s1 <= front_d;
		end
	end

	// A zero divisor only arises with a zero dividend, so one stands in for it.
	always_comb begin
		prod_d.side.valid = front_s1.valid;
		prod_d.side.hi    = front_s1.hi;
		prod_d.side.base  = front_s1.base;
		prod_d.side.neg   = front_s1.neg;
		prod_d.sat_num    = {front_s1.span, 8'd0} - {8'd0, front_s1.span};
		prod_d.sat_den    = (front_s1.hi == 8'd0) ? 8'd1 : front_s1.hi;
		prod_d.hue_num    = 16'(front_s1.mag) * 16'(rgbhsv_pkg::SECTOR_SPAN);
		prod_d.hue_den    = (front_s1.span == 8'd0) ? 8'd1 : front_s1.span;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_s2 <= '0;
		end else begin
			prod_s2 <= prod_d;
		end
	end

	assign prod = prod_s2;

endmodule

`default_nettype wire

[design/rgbhsv_div.sv]
// Pipelined restoring divider, one quotient bit per register stage, for a
// 16-bit dividend whose quotient is known to fit 8 bits. Depends on rgbhsv_pkg.
`default_nettype none

module rgbhsv_div (
	input  wire logic        clk,
	input  wire logic [15:0] dividend,
	input  wire logic [7:0]  divisor,
	output logic [7:0]       quotient
);

	logic [15:0] rem_s [rgbhsv_pkg::DIV_STEPS];
	logic [7:0]  dvs_s [rgbhsv_pkg::DIV_STEPS];
	logic [7:0]  q_s   [rgbhsv_pkg::DIV_STEPS];

	for (genvar k = 0; k < rgbhsv_pkg::DIV_STEPS; k++) begin : g_step
		localparam int Shift = rgbhsv_pkg::DIV_STEPS - 1 - k;

		logic [15:0] rem_in;
		logic [7:0]  dvs_in;
		logic [7:0]  q_in;
		logic [15:0] trial;

		if (k == 0) begin : g_first
			assign rem_in = dividend;
			assign dvs_in = divisor;
			assign q_in   = 8'd0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign dvs_in = dvs_s[k-1];
			assign q_in   = q_s[k-1];
		end

		assign trial = {8'd0, dvs_in} << Shift;

		always_ff @(posedge clk) begin
			dvs_s[k] <= dvs_in;
			if (rem_in >= trial) begin
				rem_s[k] <= rem_in - trial;
				q_s[k]   <= q_in | (8'd1 << Shift);
			end else begin
				rem_s[k] <= rem_in;
				q_s[k]   <= q_in;
			end
		end
	end

	assign quotient = q_s[rgbhsv_pkg::DIV_STEPS-1];

endmodule

`default_nettype wire

[design/rgb_to_hsv_converter_core.sv]
// RGB to HSV converter top level; uses rgbhsv_pkg, rgbhsv_front and rgbhsv_div.
// From the accepting edge, an item passes two front stages, eight divider
// stages and one output register before done is high.
// Throughput is one item per cycle; busy stays low as the receiver cannot stall.
// Reset clears the front and side registers and the done flag, so no result is
// strobed until new items arrive; divider and output data are left as they are.
`default_nettype none

module rgb_to_hsv_converter_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire rgbhsv_pkg::pixel_t pixel,
	output rgbhsv_pkg::hsv_t        result,
	output logic                    done
);

	// The pipeline never holds, so an item is taken in every cycle that start is high.
	assign busy = 1'b0;

	rgbhsv_pkg::prod_t prod;

	rgbhsv_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start),
		.pixel    (pixel),
		.prod     (prod)
	);

	// Saturation is 255*(max-min)/max; the quotient never exceeds 255.
	logic [7:0] sat_q;

	rgbhsv_div u_sat_div (
		.clk      (clk),
		.dividend (prod.sat_num),
		.divisor  (prod.sat_den),
		.quotient (sat_q)
	);

	// Hue offset is 43*|difference|/(max-min); it never exceeds 43.
	logic [7:0] hue_q;

	rgbhsv_div u_hue_div (
		.clk      (clk),
		.dividend (prod.hue_num),
		.divisor  (prod.hue_den),
		.quotient (hue_q)
	);

	// The sector base, sign and brightness travel beside the dividers so that
	// they meet the quotients in the same cycle.
	rgbhsv_pkg::side_t side_s [rgbhsv_pkg::DIV_STEPS];

	for (genvar k = 0; k < rgbhsv_pkg::DIV_STEPS; k++) begin : g_side
		rgbhsv_pkg::side_t side_in;

		if (k == 0) begin : g_first
			assign side_in = prod.side;
		end else begin : g_next
			assign side_in = side_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_s[k] <= '0;
			end else begin
				side_s[k] <= side_in;
			end
		end
	end

	rgbhsv_pkg::side_t side_last;
	rgbhsv_pkg::hsv_t  result_d;
	rgbhsv_pkg::hsv_t  result_s11;
	logic              done_s11;

	assign side_last = side_s[rgbhsv_pkg::DIV_STEPS-1];

	// Division toward zero of a signed difference equals the floored quotient of
	// its magnitude with the sign put back. Black and grey pixels need no special
	// handling here: their dividends are zero and their base is the red sector's.
	always_comb begin
		result_d.hue        = side_last.neg ? (side_last.base - hue_q)
		                                    : (side_last.base + hue_q);
		result_d.saturation = sat_q;
		result_d.brightness = side_last.hi;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s11 <= 1'b0;
		end else begin
			done_s11 <= side_last.valid;
		end
	end

	always_ff @(posedge clk) begin
		result_s11 <= result_d;
	end

	assign result = result_s11;
	assign done   = done_s11;

`ifndef ASSERT_OFF
	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(rgbhsv_pkg::PIPE_LATENCY) done)
		else $error("accepted item produced no result at the expected cycle");

	a_latency_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, rgbhsv_pkg::PIPE_LATENCY))
		else $error("result strobed without a matching accepted item");

	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.brightness == 8'd0)) |->
		((result.hue == 8'd0) && (result.saturation == 8'd0)))
		else $error("black pixel gave non-zero hue or saturation");
`endif

endmodule

`default_nettype wire
